[rtl/core/irs_pkg.sv]
// Shared types, widths and codes of the image resample scaler.
package irs_pkg;

    // Default frame store geometry
    localparam int DEF_MAX_WIDTH    = 256;
    localparam int DEF_MAX_HEIGHT   = 256;
    localparam int DEF_MAX_CHANNELS = 4;

    // Coordinate, fraction, quotient, weight and kernel distance widths
    localparam int CW = 9;
    localparam int FW = 14;
    localparam int QW = CW + FW;
    localparam int WW = 17;
    localparam int TW = 16;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RESAMPLE_MODE = 3'd5;

    // Resampling modes
    localparam logic [1:0] MODE_NEAREST  = 2'd0;
    localparam logic [1:0] MODE_BILINEAR = 2'd1;
    localparam logic [1:0] MODE_BICUBIC  = 2'd2;

    // Request actions
    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_COMPUTE = 1'b1;

    typedef struct packed {
        logic               action;
        logic [7:0]         pos_x;
        logic [7:0]         pos_y;
        logic [1:0]         chan;
        logic signed [15:0] sample_in;
    } t_req;

    typedef struct packed {
        logic signed [15:0] sample_out;
        logic [7:0]         out_x;
        logic [7:0]         out_y;
        logic [1:0]         out_chan;
    } t_rsp;

    // Effective (clamped) configuration
    typedef struct packed {
        logic [CW-1:0] sw;
        logic [CW-1:0] sh;
        logic [CW-1:0] dw;
        logic [CW-1:0] dh;
        logic [2:0]    cc;
        logic [1:0]    mode;
    } t_cfg;

    // Source position: integer part and Q0.14 fraction
    typedef struct packed {
        logic [CW-1:0] x0;
        logic [FW-1:0] fx;
        logic [CW-1:0] y0;
        logic [FW-1:0] fy;
    } t_map;

    // Tap list for the accumulate engine
    typedef struct packed {
        logic [1:0]             last_x;
        logic [1:0]             last_y;
        logic [3:0][CW-1:0]     sx;
        logic [3:0][CW-1:0]     sy;
        logic [3:0][WW-1:0]     wx;
        logic [3:0][WW-1:0]     wy;
    } t_taps;

endpackage

[rtl/core/irs_req_if.sv]
// Valid/ready request channel with a typed payload.
interface irs_req_if #(parameter type t_payload = logic);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[rtl/core/irs_ram.sv]
// Generic single-port RAM with registered read data.
module irs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One access per cycle: write or read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/core/irs_map.sv]
// Position mapping pipeline: pos*src, then a bit-per-stage divide by dst.
module irs_map (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  logic          i_valid,
    input  irs_pkg::t_req i_item,
    input  irs_pkg::t_cfg i_cfg,
    output logic          o_valid,
    output irs_pkg::t_req o_item,
    output irs_pkg::t_map o_map
);
    import irs_pkg::*;

    localparam int NUMW = 8 + CW;

    // One restoring divide step: {quotient bit, new remainder}
    function automatic logic [CW:0] div_step(input logic [CW-1:0] rem, input logic din,
                                             input logic [CW-1:0] d);
        logic [CW:0] trial;
        logic [CW:0] diff;
        trial = {rem, din};
        diff  = trial - {1'b0, d};
        if (trial >= {1'b0, d}) begin
            return {1'b1, diff[CW-1:0]};
        end else begin
            return {1'b0, trial[CW-1:0]};
        end
    endfunction

    logic [QW:0]     r_v;
    t_req            r_item [QW+1];
    logic [NUMW-1:0] r_nx [QW+1];
    logic [NUMW-1:0] r_ny [QW+1];
    logic [CW-1:0]   r_rx [QW+1];
    logic [CW-1:0]   r_ry [QW+1];
    logic [QW-1:0]   r_qx [QW+1];
    logic [QW-1:0]   r_qy [QW+1];
    logic [NUMW-1:0] w_nx;
    logic [NUMW-1:0] w_ny;

    // Stage 0: numerators
    assign w_nx = NUMW'(i_item.pos_x) * NUMW'(i_cfg.sw);
    assign w_ny = NUMW'(i_item.pos_y) * NUMW'(i_cfg.sh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_adv) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_item[0] <= i_item;
            r_nx[0]   <= w_nx;
            r_ny[0]   <= w_ny;
            r_rx[0]   <= CW'(w_nx[NUMW-1:CW]);
            r_ry[0]   <= CW'(w_ny[NUMW-1:CW]);
            r_qx[0]   <= '0;
            r_qy[0]   <= '0;
        end
    end

    // Divide stages: one quotient bit each, integer bits first
    for (genvar k = 1; k <= QW; k++) begin : g_div
        localparam int B = QW - k;
        logic        w_bx;
        logic        w_by;
        logic [CW:0] w_sx;
        logic [CW:0] w_sy;

        if (B >= FW) begin : g_bit
            assign w_bx = r_nx[k-1][B-FW];
            assign w_by = r_ny[k-1][B-FW];
        end else begin : g_zero
            assign w_bx = 1'b0;
            assign w_by = 1'b0;
        end

        assign w_sx = div_step(r_rx[k-1], w_bx, i_cfg.dw);
        assign w_sy = div_step(r_ry[k-1], w_by, i_cfg.dh);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_adv) begin
                r_v[k] <= r_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_item[k] <= r_item[k-1];
                r_nx[k]   <= r_nx[k-1];
                r_ny[k]   <= r_ny[k-1];
                r_rx[k]   <= w_sx[CW-1:0];
                r_ry[k]   <= w_sy[CW-1:0];
                r_qx[k]   <= {r_qx[k-1][QW-2:0], w_sx[CW]};
                r_qy[k]   <= {r_qy[k-1][QW-2:0], w_sy[CW]};
            end
        end
    end

    assign o_valid  = r_v[QW];
    assign o_item   = r_item[QW];
    assign o_map.x0 = r_qx[QW][QW-1:FW];
    assign o_map.fx = r_qx[QW][FW-1:0];
    assign o_map.y0 = r_qy[QW][QW-1:FW];
    assign o_map.fy = r_qy[QW][FW-1:0];
endmodule

[rtl/core/irs_kern.sv]
// Kernel pipeline: tap coordinates, Keys weights and per-mode tap list.
module irs_kern #(
    parameter int MAX_WIDTH    = irs_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT   = irs_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_CHANNELS = irs_pkg::DEF_MAX_CHANNELS,
    localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  logic           i_valid,
    input  irs_pkg::t_req  i_item,
    input  irs_pkg::t_map  i_map,
    input  irs_pkg::t_cfg  i_cfg,
    output logic           o_valid,
    output irs_pkg::t_req  o_item,
    output irs_pkg::t_taps o_taps,
    output logic [AW-1:0]  o_addr
);
    import irs_pkg::*;

    localparam int NW = 52;
    localparam logic [TW-1:0] T_ONE = TW'(1 << FW);
    localparam logic [TW-1:0] T_TWO = TW'(2 << FW);
    localparam logic [WW-1:0] W_ONE = WW'(1 << FW);

    // Keys kernel (a = -0.5), |t| in Q14, weight rounded to Q2.14
    function automatic logic [WW-1:0] keys_w(input logic [TW-1:0] t,
                                             input logic [2*TW-1:0] t2,
                                             input logic [3*TW-1:0] t3);
        logic signed [NW-1:0] s_t;
        logic signed [NW-1:0] s_t2;
        logic signed [NW-1:0] s_t3;
        logic signed [NW-1:0] n;
        logic signed [NW-1:0] r;
        s_t  = NW'(t);
        s_t2 = NW'(t2);
        s_t3 = NW'(t3);
        if (t <= T_ONE) begin
            n = 3 * s_t3 - ((5 * s_t2) <<< FW) + (NW'(1) <<< 43);
        end else begin
            n = -s_t3 + ((5 * s_t2) <<< FW) - (s_t <<< 31) + (NW'(1) <<< 44);
        end
        r = (n + (NW'(1) <<< 28)) >>> 29;
        return r[WW-1:0];
    endfunction

    // Clamped cubic neighbor coordinates x0-1 .. x0+2
    function automatic logic [3:0][CW-1:0] nbr(input logic [CW-1:0] c, input logic [CW-1:0] s);
        logic [CW-1:0]    lim;
        logic [CW:0]      p1;
        logic [CW:0]      p2;
        logic [3:0][CW-1:0] res;
        lim    = s - CW'(1);
        p1     = {1'b0, c} + (CW+1)'(1);
        p2     = {1'b0, c} + (CW+1)'(2);
        res[0] = (c == '0) ? '0 : c - CW'(1);
        res[1] = c;
        res[2] = (p1 > {1'b0, lim}) ? lim : p1[CW-1:0];
        res[3] = (p2 > {1'b0, lim}) ? lim : p2[CW-1:0];
        return res;
    endfunction

    logic [TW-1:0] w_tx [4];
    logic [TW-1:0] w_ty [4];

    // Stage 1 registers
    logic               r1_v;
    t_req               r1_item;
    t_map               r1_map;
    logic [AW-1:0]      r1_addr;
    logic [TW-1:0]      r1_tx [4];
    logic [TW-1:0]      r1_ty [4];
    logic [2*TW-1:0]    r1_t2x [4];
    logic [2*TW-1:0]    r1_t2y [4];
    logic [3:0][CW-1:0] r1_cx;
    logic [3:0][CW-1:0] r1_cy;

    // Stage 2 registers
    logic               r2_v;
    t_req               r2_item;
    t_map               r2_map;
    logic [AW-1:0]      r2_addr;
    logic [TW-1:0]      r2_tx [4];
    logic [TW-1:0]      r2_ty [4];
    logic [2*TW-1:0]    r2_t2x [4];
    logic [2*TW-1:0]    r2_t2y [4];
    logic [3*TW-1:0]    r2_t3x [4];
    logic [3*TW-1:0]    r2_t3y [4];
    logic [3:0][CW-1:0] r2_cx;
    logic [3:0][CW-1:0] r2_cy;

    // Stage 3 registers
    logic               r3_v;
    t_req               r3_item;
    t_taps              r3_taps;
    logic [AW-1:0]      r3_addr;
    t_taps              n_taps;

    // Kernel distances for offsets -1, 0, +1, +2
    assign w_tx[0] = T_ONE + TW'(i_map.fx);
    assign w_tx[1] = TW'(i_map.fx);
    assign w_tx[2] = T_ONE - TW'(i_map.fx);
    assign w_tx[3] = T_TWO - TW'(i_map.fx);
    assign w_ty[0] = T_ONE + TW'(i_map.fy);
    assign w_ty[1] = TW'(i_map.fy);
    assign w_ty[2] = T_ONE - TW'(i_map.fy);
    assign w_ty[3] = T_TWO - TW'(i_map.fy);

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (i_adv) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    // Stage 1: squares, neighbor coordinates, load address
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_item <= i_item;
            r1_map  <= i_map;
            r1_addr <= AW'((int'(i_item.pos_y) * MAX_WIDTH + int'(i_item.pos_x))
                           * MAX_CHANNELS + int'(i_item.chan));
            r1_cx   <= nbr(i_map.x0, i_cfg.sw);
            r1_cy   <= nbr(i_map.y0, i_cfg.sh);
            for (int i = 0; i < 4; i++) begin
                r1_tx[i]  <= w_tx[i];
                r1_ty[i]  <= w_ty[i];
                r1_t2x[i] <= (2*TW)'(w_tx[i]) * (2*TW)'(w_tx[i]);
                r1_t2y[i] <= (2*TW)'(w_ty[i]) * (2*TW)'(w_ty[i]);
            end
        end
    end

    // Stage 2: cubes
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r2_item <= r1_item;
            r2_map  <= r1_map;
            r2_addr <= r1_addr;
            r2_cx   <= r1_cx;
            r2_cy   <= r1_cy;
            for (int i = 0; i < 4; i++) begin
                r2_tx[i]  <= r1_tx[i];
                r2_ty[i]  <= r1_ty[i];
                r2_t2x[i] <= r1_t2x[i];
                r2_t2y[i] <= r1_t2y[i];
                r2_t3x[i] <= (3*TW)'(r1_t2x[i]) * (3*TW)'(r1_tx[i]);
                r2_t3y[i] <= (3*TW)'(r1_t2y[i]) * (3*TW)'(r1_ty[i]);
            end
        end
    end

    // Stage 3: weights and tap list for the active mode
    always_comb begin
        n_taps = '0;
        unique case (i_cfg.mode)
            MODE_BICUBIC: begin
                n_taps.last_x = 2'd3;
                n_taps.last_y = 2'd3;
                n_taps.sx     = r2_cx;
                n_taps.sy     = r2_cy;
                for (int i = 0; i < 4; i++) begin
                    n_taps.wx[i] = keys_w(r2_tx[i], r2_t2x[i], r2_t3x[i]);
                    n_taps.wy[i] = keys_w(r2_ty[i], r2_t2y[i], r2_t3y[i]);
                end
            end
            MODE_BILINEAR: begin
                n_taps.last_x = 2'd1;
                n_taps.last_y = 2'd1;
                n_taps.sx[0]  = r2_cx[1];
                n_taps.sx[1]  = r2_cx[2];
                n_taps.sy[0]  = r2_cy[1];
                n_taps.sy[1]  = r2_cy[2];
                n_taps.wx[0]  = W_ONE - WW'(r2_map.fx);
                n_taps.wx[1]  = WW'(r2_map.fx);
                n_taps.wy[0]  = W_ONE - WW'(r2_map.fy);
                n_taps.wy[1]  = WW'(r2_map.fy);
            end
            default: begin
                // nearest, and the unused mode code
                n_taps.sx[0] = r2_cx[1];
                n_taps.sy[0] = r2_cy[1];
                n_taps.wx[0] = W_ONE;
                n_taps.wy[0] = W_ONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r3_item <= r2_item;
            r3_addr <= r2_addr;
            r3_taps <= n_taps;
        end
    end

    assign o_valid = r3_v;
    assign o_item  = r3_item;
    assign o_taps  = r3_taps;
    assign o_addr  = r3_addr;
endmodule

[rtl/core/irs_tap.sv]
// Tap engine: frame store, sequential tap reads, multiply-accumulate, result register.
module irs_tap #(
    parameter int MAX_WIDTH    = irs_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT   = irs_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_CHANNELS = irs_pkg::DEF_MAX_CHANNELS,
    localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  irs_pkg::t_req  i_item,
    input  irs_pkg::t_taps i_taps,
    input  logic [AW-1:0]  i_addr,
    output logic           o_ready,
    output logic           o_valid,
    output irs_pkg::t_rsp  o_rsp,
    input  logic           i_ready
);
    import irs_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS;
    localparam int PW    = 2 * WW;
    localparam int MW    = PW + 16;
    localparam int ACCW  = 52;
    localparam int RW    = ACCW - 28;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0]            r_state;
    t_req                  r_item;
    t_taps                 r_taps;
    logic [1:0]            r_i;
    logic [1:0]            r_j;
    logic                  r_v1;
    logic                  r_v2;
    logic signed [PW-1:0]  r_wp;
    logic signed [MW-1:0]  r_prod;
    logic signed [ACCW-1:0] r_acc;
    logic                  r_ov;
    t_rsp                  r_rsp;

    logic                  w_issue;
    logic                  w_load;
    logic                  w_last_tap;
    logic                  w_finish;
    logic [AW-1:0]         w_tap_addr;
    logic [AW-1:0]         w_addr;
    logic [15:0]           w_rdata;
    logic signed [ACCW-1:0] w_sum;
    logic signed [RW-1:0]  w_rnd;
    logic signed [15:0]    w_sat;

    // Frame store
    irs_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_load),
        .i_addr  (w_addr),
        .i_wdata (i_item.sample_in),
        .o_rdata (w_rdata)
    );

    // Memory port: load writes when idle, tap reads while running
    assign w_issue    = (r_state == ST_RUN);
    assign w_load     = (r_state == ST_IDLE) && i_valid && (i_item.action == ACT_LOAD);
    assign w_tap_addr = AW'((int'(r_taps.sy[r_j]) * MAX_WIDTH + int'(r_taps.sx[r_i]))
                            * MAX_CHANNELS + int'(r_item.chan));
    assign w_addr     = w_issue ? w_tap_addr : i_addr;
    assign w_last_tap = (r_i == r_taps.last_x) && (r_j == r_taps.last_y);
    assign w_finish   = (r_state == ST_DRAIN) && !r_v1 && !r_v2 && (!r_ov || i_ready);
    assign o_ready    = (r_state == ST_IDLE);

    // Round Q28 sum to Q8.8 and saturate
    assign w_sum = r_acc + (ACCW'(1) <<< 27);
    assign w_rnd = RW'(w_sum >>> 28);
    always_comb begin
        if (w_rnd > RW'(32767)) begin
            w_sat = 16'sh7FFF;
        end else if (w_rnd < -RW'(32768)) begin
            w_sat = -16'sh8000;
        end else begin
            w_sat = w_rnd[15:0];
        end
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_v1 <= w_issue;
            r_v2 <= r_v1;
            if (w_finish) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid && i_item.action == ACT_COMPUTE) begin
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (w_last_tap) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (w_finish) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Request capture and tap counters
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE) begin
            r_i <= '0;
            r_j <= '0;
            if (i_valid) begin
                r_item <= i_item;
                r_taps <= i_taps;
            end
        end else if (w_issue) begin
            if (r_i == r_taps.last_x) begin
                r_i <= '0;
                r_j <= r_j + 2'd1;
            end else begin
                r_i <= r_i + 2'd1;
            end
        end
    end

    // Weight product, sample product, accumulate
    always_ff @(posedge i_clk) begin
        r_wp   <= $signed(r_taps.wy[r_j]) * $signed(r_taps.wx[r_i]);
        r_prod <= r_wp * $signed(w_rdata);
        if (r_state == ST_IDLE) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + ACCW'(r_prod);
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_rsp.sample_out <= w_sat;
            r_rsp.out_x      <= r_item.pos_x;
            r_rsp.out_y      <= r_item.pos_y;
            r_rsp.out_chan   <= r_item.chan;
        end
    end

    assign o_valid = r_ov;
    assign o_rsp   = r_rsp;
endmodule

[rtl/core/image_resample_scaler.sv]
// Image resample scaler: a load request writes one Q8.8 source sample into the frame
// store; a compute request returns one destination sample in nearest, bilinear or
// bicubic mode. Requests pass a 27-stage mapping/kernel pipeline (one request per
// cycle while the tap engine holds no waiting request), then a tap engine that owns
// the single-port frame memory and reads one neighbor per cycle. The engine writes a
// load as it arrives; a compute reads its taps in turn and then drains, and no new
// request is taken until it is done. Out-of-range loads are dropped and out-of-range
// computes give no result.
module image_resample_scaler #(
    parameter int MAX_WIDTH    = irs_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT   = irs_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_CHANNELS = irs_pkg::DEF_MAX_CHANNELS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    irs_req_if.sink                         i_req,
    irs_req_if.source                       o_rsp,
    input  logic                            i_cfg_we,
    input  logic [irs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [irs_pkg::CW-1:0]          i_cfg_data
);
    import irs_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS);
    localparam logic [12:0] LIM_W = 13'(MAX_WIDTH);
    localparam logic [12:0] LIM_H = 13'(MAX_HEIGHT);
    localparam logic [2:0]  LIM_C = 3'(MAX_CHANNELS);

    logic [CW-1:0] r_src_w;
    logic [CW-1:0] r_src_h;
    logic [CW-1:0] r_dst_w;
    logic [CW-1:0] r_dst_h;
    logic [2:0]    r_chans;
    logic [1:0]    r_mode;

    t_cfg          w_cfg;
    t_req          w_req;
    logic          w_in_ok;
    logic          w_adv;

    logic          m_valid;
    t_req          m_item;
    t_map          m_map;
    logic          k_valid;
    t_req          k_item;
    t_taps         k_taps;
    logic [AW-1:0] k_addr;
    logic          e_ready;
    t_rsp          e_rsp;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= CW'(256);
            r_src_h <= CW'(256);
            r_dst_w <= CW'(256);
            r_dst_h <= CW'(256);
            r_chans <= 3'd3;
            r_mode  <= MODE_BILINEAR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SRC_WIDTH:     r_src_w <= i_cfg_data;
                CFG_SRC_HEIGHT:    r_src_h <= i_cfg_data;
                CFG_DST_WIDTH:     r_dst_w <= i_cfg_data;
                CFG_DST_HEIGHT:    r_dst_h <= i_cfg_data;
                CFG_CHANNEL_COUNT: r_chans <= i_cfg_data[2:0];
                CFG_RESAMPLE_MODE: r_mode  <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // Effective sizes after clamping
    always_comb begin
        w_cfg.sw = (r_src_w == '0) ? CW'(1) :
                   (({4'b0, r_src_w} > LIM_W) ? LIM_W[CW-1:0] : r_src_w);
        w_cfg.sh = (r_src_h == '0) ? CW'(1) :
                   (({4'b0, r_src_h} > LIM_H) ? LIM_H[CW-1:0] : r_src_h);
        w_cfg.dw = (r_dst_w == '0) ? CW'(1) : r_dst_w;
        w_cfg.dh = (r_dst_h == '0) ? CW'(1) : r_dst_h;
        w_cfg.cc = (r_chans == '0) ? 3'd1 : ((r_chans > LIM_C) ? LIM_C : r_chans);
        w_cfg.mode = r_mode;
    end

    // Range filter at entry
    assign w_req = i_req.payload;
    always_comb begin
        if (w_req.action == ACT_LOAD) begin
            w_in_ok = ({1'b0, w_req.pos_x} < w_cfg.sw) && ({1'b0, w_req.pos_y} < w_cfg.sh)
                      && ({1'b0, w_req.chan} < w_cfg.cc);
        end else begin
            w_in_ok = ({1'b0, w_req.pos_x} < w_cfg.dw) && ({1'b0, w_req.pos_y} < w_cfg.dh)
                      && ({1'b0, w_req.chan} < w_cfg.cc);
        end
    end

    // Whole pipeline moves unless the engine holds a waiting request
    assign w_adv       = !k_valid || e_ready;
    assign i_req.ready = w_adv;

    irs_map u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (i_req.valid && w_in_ok),
        .i_item  (w_req),
        .i_cfg   (w_cfg),
        .o_valid (m_valid),
        .o_item  (m_item),
        .o_map   (m_map)
    );

    irs_kern #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_kern (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (m_valid),
        .i_item  (m_item),
        .i_map   (m_map),
        .i_cfg   (w_cfg),
        .o_valid (k_valid),
        .o_item  (k_item),
        .o_taps  (k_taps),
        .o_addr  (k_addr)
    );

    irs_tap #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_tap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (k_valid),
        .i_item  (k_item),
        .i_taps  (k_taps),
        .i_addr  (k_addr),
        .o_ready (e_ready),
        .o_valid (o_rsp.valid),
        .o_rsp   (e_rsp),
        .i_ready (o_rsp.ready)
    );

    assign o_rsp.payload = e_rsp;
endmodule
